>>> rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wildcard byte pattern scanner.
// Used by the register block, the window cells, the top level and the checker.
package wbps_pkg;

   localparam int PatternMaxDefault = 32;
   localparam int OffsetBitsDefault = 32;
   localparam int PatternBytes      = 32;
   localparam int LenBits           = 6;
   localparam int WordBits          = 64;
   localparam int MaskBits          = 32;
   localparam int CsrIndexBits      = 3;
   localparam int OutOffsetBits     = 32;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_WORD_0 = 3'd1,
      CSR_PATTERN_WORD_1 = 3'd2,
      CSR_PATTERN_WORD_2 = 3'd3,
      CSR_PATTERN_WORD_3 = 3'd4,
      CSR_WILDCARD_MASK  = 3'd5
   } csr_index_type;

   localparam logic RSP_FOUND     = 1'b0;
   localparam logic RSP_NOT_FOUND = 1'b1;

   typedef struct packed {
      logic [LenBits-1:0]                active_len;
      logic [PatternBytes-1:0][7:0]      pattern;
      logic [MaskBits-1:0]               wild;
   } scan_cfg_type;

endpackage

>>> rtl/wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps
// Wildcard byte pattern scanner, top level.
// Depends on wbps_pkg, wbps_cfg_regs and wbps_cell.
//
// Usage:
//   The req channel takes one image byte per word, with req_final_byte set
//   on the last byte of an image. The rsp channel gives at most one word per
//   image: status found with the offset of the first matching byte, or status
//   not found (offset 0) when the final byte arrives without a match.
//   The csr port loads pattern length, four pattern words and the wildcard
//   mask; write it only while no image is in flight.
//   Throughput is one byte per cycle while req_stall is low: a row of PATTERN_MAX cells shifts the
//   window and every cell compares in parallel in the accept cycle.
//   The rsp word appears in the cycle after its byte is accepted.
//   The rsp word sits in an output register; req_stall rises only while that
//   register is full and the receiver stalls it, so a new byte is taken in
//   the same cycle the pending word is drained.
//   Reset (synchronous) empties the output register, clears the window,
//   byte count and match flag, and loads length 1, zero pattern and mask.
module wildcard_byte_pattern_scan #(
   parameter int PATTERN_MAX = wbps_pkg::PatternMaxDefault,
   parameter int OFFSET_BITS = wbps_pkg::OffsetBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_image_byte,
   input  logic                                 req_final_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_status,
   output logic [wbps_pkg::OutOffsetBits-1:0]   rsp_match_offset,
   input  logic                                 csr_write_enable,
   input  logic [wbps_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [wbps_pkg::WordBits-1:0]        csr_write_data
);

   localparam int OutW = wbps_pkg::OutOffsetBits;

   wbps_pkg::scan_cfg_type cfg;

   logic [PATTERN_MAX-1:0][7:0] win;
   logic [PATTERN_MAX-1:0]      eq;

   logic                   accept;
   logic                   clear_win;
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic                   reported_ff;
   logic                   reported_in;
   logic [OFFSET_BITS-1:0] len_m1;
   logic [OFFSET_BITS-1:0] offset;
   logic                   hit;
   logic                   miss;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_status_ff;
   logic [OutW-1:0]        rsp_offset_ff;

   wbps_cfg_regs #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign clear_win = reset || (accept && req_final_byte);

   // Row of window cells, newest byte enters cell 0
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [7:0] cell_in;
      if (k == 0) begin : g_head
         assign cell_in = req_image_byte;
      end else begin : g_body
         assign cell_in = win[k-1];
      end
      wbps_cell #(
         .IDX (k)
      ) u_cell (
         .clock    (clock),
         .clear    (clear_win),
         .shift_en (accept),
         .byte_in  (cell_in),
         .cfg      (cfg),
         .byte_out (win[k]),
         .eq       (eq[k])
      );
   end

   // Match decision for the byte being accepted
   assign len_m1 = OFFSET_BITS'(cfg.active_len) - OFFSET_BITS'(1);
   assign offset = count_ff - len_m1;
   assign hit    = !reported_ff && (count_ff >= len_m1) && (&eq);
   assign miss   = req_final_byte && !reported_ff && !hit;

   // Advance byte count and match flag; drop both at image end
   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_final_byte) begin
            count_in    = '0;
            reported_in = 1'b0;
         end else begin
            if (count_ff != '1) begin
               count_in = count_ff + OFFSET_BITS'(1);
            end
            reported_in = reported_ff || hit;
         end
      end
   end

   // Output register: load on a result, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && (hit || miss)) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload until a new result loads
   always_ff @(posedge clock) begin
      if (accept && (hit || miss)) begin
         rsp_status_ff <= hit ? wbps_pkg::RSP_FOUND : wbps_pkg::RSP_NOT_FOUND;
         rsp_offset_ff <= hit ? OutW'(offset) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule

>>> rtl/wbps_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the scanner: pattern length, pattern bytes, wildcard mask.
// Depends on wbps_pkg; hands a clamped view of the settings to the cells.
module wbps_cfg_regs #(
   parameter int PATTERN_MAX = wbps_pkg::PatternMaxDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [wbps_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [wbps_pkg::WordBits-1:0]        csr_write_data,
   output wbps_pkg::scan_cfg_type               cfg
);

   logic [wbps_pkg::LenBits-1:0]       length_ff;
   logic [3:0][wbps_pkg::WordBits-1:0] words_ff;
   logic [wbps_pkg::MaskBits-1:0]      mask_ff;

   // Take register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= wbps_pkg::LenBits'(1);
         words_ff  <= '0;
         mask_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wbps_pkg::CSR_PATTERN_LENGTH: length_ff <= csr_write_data[wbps_pkg::LenBits-1:0];
            wbps_pkg::CSR_PATTERN_WORD_0: words_ff[0] <= csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD_1: words_ff[1] <= csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD_2: words_ff[2] <= csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD_3: words_ff[3] <= csr_write_data;
            wbps_pkg::CSR_WILDCARD_MASK:  mask_ff <= csr_write_data[wbps_pkg::MaskBits-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the length into 1..PATTERN_MAX
   always_comb begin
      if (length_ff == '0) begin
         cfg.active_len = wbps_pkg::LenBits'(1);
      end else if (length_ff > wbps_pkg::LenBits'(PATTERN_MAX)) begin
         cfg.active_len = wbps_pkg::LenBits'(PATTERN_MAX);
      end else begin
         cfg.active_len = length_ff;
      end
      cfg.pattern = words_ff;
      cfg.wild    = mask_ff;
   end

endmodule

>>> rtl/wbps_cell.sv
`timescale 1ns / 1ps
// One window cell: holds one image byte, passes it on each accepted word,
// and checks the byte arriving into it against its pattern position. Uses wbps_pkg.
module wbps_cell #(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  logic                    clear,
   input  logic                    shift_en,
   input  logic [7:0]              byte_in,
   input  wbps_pkg::scan_cfg_type  cfg,
   output logic [7:0]              byte_out,
   output logic                    eq
);

   localparam logic [wbps_pkg::LenBits-1:0] IdxL = wbps_pkg::LenBits'(IDX);

   logic [7:0]                   byte_ff;
   logic [wbps_pkg::LenBits-1:0] pos_in_pattern;
   logic                         in_use;
   logic [4:0]                   sel;

   // Hold the window byte, advance on accept
   always_ff @(posedge clock) begin
      if (clear) begin
         byte_ff <= '0;
      end else if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

   // This cell lines up with pattern byte (length - 1 - IDX)
   assign in_use         = IdxL < cfg.active_len;
   assign pos_in_pattern = cfg.active_len - IdxL - wbps_pkg::LenBits'(1);
   assign sel            = pos_in_pattern[4:0];
   assign eq = !in_use || cfg.wild[sel] || (byte_in == cfg.pattern[sel]);

endmodule

>>> rtl/wbps_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the wildcard byte pattern scanner, bound to the top level.
// Depends on wbps_pkg for the result codes and widths.
module wbps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_status,
   input logic [wbps_pkg::OutOffsetBits-1:0]  rsp_match_offset
);

   // Output register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Input side only stalls behind a full, stalled output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a blocked rsp word");

   // Not-found words carry offset zero
   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == wbps_pkg::RSP_NOT_FOUND)) |-> (rsp_match_offset == '0))
      else $error("not-found word with nonzero offset");

   // A new rsp word follows an accepted req word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("rsp word without an accepted req word");

   // Stalled rsp word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_match_offset)
                                   && $stable(rsp_status)))
      else $error("stalled rsp word changed");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_match_offset (rsp_match_offset)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for wildcard_byte_pattern_scan: drives images and pattern loads,
// predicts each found / not-found word and checks it on the rsp channel.
// Depends on wbps_pkg and the wildcard_byte_pattern_scan RTL.
module tb;

   // Register slots past the mapped ones; writes there must be dropped
   localparam logic [wbps_pkg::CsrIndexBits-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [wbps_pkg::CsrIndexBits-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                               status;
      logic [wbps_pkg::OutOffsetBits-1:0] offset;
   } scan_report_type;

   // Tracks the scanner state and holds the reports still owed by the block
   class scan_tracker;
      logic [wbps_pkg::LenBits-1:0]                len_reg;
      logic [wbps_pkg::PatternBytes-1:0][7:0]      pattern;
      logic [wbps_pkg::MaskBits-1:0]               wild;
      logic [7:0]                                  window [wbps_pkg::PatternBytes];
      logic [31:0]                                 seen;
      bit                                          reported;
      scan_report_type                             awaited[$];
      int                                          errors;
      int                                          found_words;
      int                                          missing_words;

      function new();
         len_reg = wbps_pkg::LenBits'(1);
         pattern = '0;
         wild    = '0;
         errors  = 0;
         found_words = 0;
         missing_words = 0;
         clear_image();
      endfunction

      function void clear_image();
         foreach (window[i]) window[i] = 8'h00;
         seen     = '0;
         reported = 1'b0;
      endfunction

      // Zero acts as one, anything past the window acts as the full window
      function int unsigned active_len(logic [wbps_pkg::LenBits-1:0] raw);
         if (raw == 0) return 1;
         if (raw > wbps_pkg::PatternBytes) return wbps_pkg::PatternBytes;
         return raw;
      endfunction

      function void write_reg(logic [wbps_pkg::CsrIndexBits-1:0] idx,
                              logic [wbps_pkg::WordBits-1:0] data);
         case (idx)
            wbps_pkg::CSR_PATTERN_LENGTH: len_reg = data[wbps_pkg::LenBits-1:0];
            wbps_pkg::CSR_PATTERN_WORD_0: pattern[7:0]   = data;
            wbps_pkg::CSR_PATTERN_WORD_1: pattern[15:8]  = data;
            wbps_pkg::CSR_PATTERN_WORD_2: pattern[23:16] = data;
            wbps_pkg::CSR_PATTERN_WORD_3: pattern[31:24] = data;
            wbps_pkg::CSR_WILDCARD_MASK:  wild = data[wbps_pkg::MaskBits-1:0];
            default: ;
         endcase
      endfunction

      // Shift one accepted image byte in and queue the report it causes, if any
      function void note_byte(logic [7:0] value, logic last);
         int unsigned     n;
         bit              hit;
         bit              produced;
         scan_report_type rep;
         n = active_len(len_reg);
         produced = 1'b0;
         for (int k = wbps_pkg::PatternBytes - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = value;
         if (!reported && seen >= n - 1) begin
            hit = 1'b1;
            for (int j = 0; j < n; j++)
               if (!wild[j] && window[n-1-j] != pattern[j]) hit = 1'b0;
            if (hit) begin
               reported = 1'b1;
               produced = 1'b1;
               rep.status = wbps_pkg::RSP_FOUND;
               rep.offset = seen - (n - 1);
               awaited = {awaited, rep};
            end
         end
         if (seen != 32'hFFFF_FFFF) seen++;
         if (last) begin
            if (!produced && !reported) begin
               rep.status = wbps_pkg::RSP_NOT_FOUND;
               rep.offset = '0;
               awaited = {awaited, rep};
            end
            clear_image();
         end
      endfunction

      function void note_error();
         errors++;
      endfunction

      function void check_result(logic status, logic [wbps_pkg::OutOffsetBits-1:0] offset);
         scan_report_type want;
         if (awaited.size() == 0) begin
            if (errors < 10)
               $display("%0t: unexpected rsp word status %0d offset %0d",
                        $time, status, offset);
            note_error();
            return;
         end
         want = awaited.pop_front();
         if (want.status == wbps_pkg::RSP_FOUND) found_words++;
         else missing_words++;
         if (status !== want.status || offset !== want.offset) begin
            if (errors < 10)
               $display("%0t: rsp mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                        $time, want.status, status, want.offset, offset);
            note_error();
         end
      endfunction

      // Count every report the block never delivered
      function void flush_leftovers();
         if (awaited.size() != 0) begin
            $display("%0d expected rsp words never arrived", awaited.size());
            errors += awaited.size();
         end
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [7:0]                           req_image_byte = 8'h00;
   logic                                 req_final_byte = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_status;
   logic [wbps_pkg::OutOffsetBits-1:0]   rsp_match_offset;
   logic                                 csr_write_enable = 1'b0;
   logic [wbps_pkg::CsrIndexBits-1:0]    csr_index = wbps_pkg::CSR_PATTERN_LENGTH;
   logic [wbps_pkg::WordBits-1:0]        csr_write_data = '0;

   scan_tracker                            tracker;
   logic [wbps_pkg::WordBits-1:0]          cfg_len_word = 64'd1;
   logic [wbps_pkg::PatternBytes-1:0][7:0] cfg_pattern = '0;
   logic [wbps_pkg::MaskBits-1:0]          cfg_mask = '0;
   logic [7:0]                             image_q[$];
   bit                                     calm = 1'b0;
   bit                                     narrow = 1'b0;
   int                                     stall_left = 0;
   int                                     bytes_sent = 0;
   int                                     images_sent = 0;
   int                                     loads_done = 0;
   int                                     directed_bytes;

   wildcard_byte_pattern_scan dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_image_byte   (req_image_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // Mostly back to back, sometimes a short pause, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Narrow mode draws from a tiny alphabet so chance matches turn up often
   function automatic logic [7:0] random_byte();
      if (!narrow) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'hA5;
      endcase
   endfunction

   // Check delivered words and stall the rsp side in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_status, rsp_match_offset);
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(input logic [wbps_pkg::CsrIndexBits-1:0] idx,
                            input logic [wbps_pkg::WordBits-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   // Load every register from the cfg_ copies; junk in unused upper bits
   task automatic load_config();
      csr_write(wbps_pkg::CSR_PATTERN_LENGTH, cfg_len_word);
      csr_write(wbps_pkg::CSR_PATTERN_WORD_0, cfg_pattern[7:0]);
      csr_write(wbps_pkg::CSR_PATTERN_WORD_1, cfg_pattern[15:8]);
      csr_write(wbps_pkg::CSR_PATTERN_WORD_2, cfg_pattern[23:16]);
      csr_write(wbps_pkg::CSR_PATTERN_WORD_3, cfg_pattern[31:24]);
      csr_write(wbps_pkg::CSR_WILDCARD_MASK, {32'($urandom), cfg_mask});
      if ($urandom_range(0, 2) == 0)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                   {32'($urandom), 32'($urandom)});
      csr_write_enable <= 1'b0;
      @(posedge clock);
      loads_done++;
   endtask

   // Hold each byte until accepted; drop valid only across a gap
   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_image_byte <= value;
      req_final_byte <= last;
      do @(posedge clock); while (req_stall);
      tracker.note_byte(value, last);
      bytes_sent++;
   endtask

   task automatic send_image();
      foreach (image_q[i]) send_byte(image_q[i], i == image_q.size() - 1);
      images_sent++;
   endtask

   // Wait for every owed word, then let the last bytes clear the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Random pattern setup, biased toward short lengths and the extremes
   task automatic pick_config();
      int r;
      int len;
      r = $urandom_range(0, 19);
      if (r < 2) len = 1;
      else if (r < 4) len = wbps_pkg::PatternBytes;
      else if (r == 4) len = 0;
      else if (r == 5) len = $urandom_range(wbps_pkg::PatternBytes + 1, 63);
      else if (r < 12) len = $urandom_range(2, 6);
      else if (r < 16) len = $urandom_range(7, 16);
      else len = $urandom_range(17, wbps_pkg::PatternBytes);
      cfg_len_word = {32'($urandom), 32'($urandom)};
      cfg_len_word[wbps_pkg::LenBits-1:0] = wbps_pkg::LenBits'(len);
      foreach (cfg_pattern[i]) cfg_pattern[i] = random_byte();
      r = $urandom_range(0, 9);
      if (r < 4) cfg_mask = '0;
      else if (r == 4) cfg_mask = '1;
      else cfg_mask = $urandom & $urandom;
   endtask

   // Mostly images holding the pattern somewhere, some with one byte broken
   task automatic build_image();
      int n;
      int len;
      int kind;
      int at;
      int j;
      n = tracker.active_len(cfg_len_word[wbps_pkg::LenBits-1:0]);
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, n);
      else len = n + $urandom_range(0, ($urandom_range(0, 9) == 0) ? 60 : 12);
      image_q.delete();
      repeat (len) image_q = {image_q, random_byte()};
      if (kind < 7 && len >= n) begin
         at = $urandom_range(0, len - n);
         for (j = 0; j < n; j++)
            if (!cfg_mask[j]) image_q[at+j] = cfg_pattern[j];
         if (kind >= 5) begin
            j = $urandom_range(0, n - 1);
            image_q[at+j] = image_q[at+j] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset pattern is one zero byte: hit mid-image, then ignore the rest
      image_q = {8'hFF, 8'h00, 8'h7E};
      send_image();
      image_q = {8'hFF};
      send_image();
      settle();

      // Length written as zero acts as one; match lands on the final byte
      cfg_len_word = 64'hFFFF_FFFF_FFFF_FFC0;
      cfg_pattern = {{31{8'h3C}}, 8'hFF};
      cfg_mask = '0;
      load_config();
      csr_write(CSR_SPARE_HI, '1);
      csr_write_enable <= 1'b0;
      image_q = {8'h12, 8'hFF};
      send_image();
      settle();

      // Four bytes with a wildcard in the middle; first image is too short
      cfg_len_word = 64'd4;
      cfg_pattern = '0;
      cfg_pattern[3:0] = 32'hDDCC_BBAA;
      cfg_mask = 32'h0000_0004;
      load_config();
      image_q = {8'hAA, 8'hBB, 8'h00};
      send_image();
      image_q = {8'hAA, 8'hAA, 8'hBB, 8'h77, 8'hDD, 8'h55};
      send_image();
      settle();

      // Every position wild: match at offset zero right away
      cfg_len_word = 64'd1;
      cfg_mask = '1;
      load_config();
      image_q = {8'h5A};
      send_image();
      image_q = {8'h00, 8'h01};
      send_image();
      directed_bytes = bytes_sent;

      // Random phases: fresh pattern, then a handful of images each
      while (bytes_sent < directed_bytes + 1900) begin
         settle();
         narrow = $urandom_range(0, 1);
         calm = ($urandom_range(0, 3) == 0);
         pick_config();
         load_config();
         repeat ($urandom_range(1, 8)) begin
            build_image();
            send_image();
         end
      end
      settle();
      tracker.flush_leftovers();

      $display("scanned %0d images, %0d bytes, across %0d pattern loads",
               images_sent, bytes_sent, loads_done);
      $display("checked %0d found and %0d not-found words, %0d errors",
               tracker.found_words, tracker.missing_words, tracker.errors);
      if (tracker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/wbps_pkg.sv
rtl/wbps_cfg_regs.sv
rtl/wbps_cell.sv
rtl/wildcard_byte_pattern_scan.sv
rtl/wbps_checker.sv
tb/tb.sv
